FILE: src/cmbb_pkg.sv
package cmbb_pkg;

  // Field widths
  localparam int ROW_W    = 10;
  localparam int BCOL_W   = 7;
  localparam int BYTE_W   = 8;
  localparam int DIM_W    = 11;
  localparam int STRIDE_W = 13;
  localparam int OFFS_W   = 22;
  localparam int START_W  = 12;
  localparam int MASK_W   = 8;
  localparam int PIX_W    = 8;
  localparam int LANES    = 8;

  // Packed stream widths, rounded up to whole bytes
  localparam int IN_RAW_W  = ROW_W + BCOL_W + BYTE_W;
  localparam int IN_DATA_W = ((IN_RAW_W + 7) / 8) * 8;
  localparam int OUT_RAW_W = OFFS_W + START_W + MASK_W + PIX_W;
  localparam int OUT_DATA_W = ((OUT_RAW_W + 7) / 8) * 8;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = STRIDE_W;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BITMAP_WIDTH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BITMAP_HEIGHT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CANVAS_WIDTH  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CANVAS_HEIGHT = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_CANVAS_STRIDE = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_INK_VALUE     = 3'd7;

  // Largest bitmap or canvas dimension; larger settings clamp to it
  localparam int MAX_DIM = 1024;

  // Geometry handed to the lane mask unit
  typedef struct packed {
    logic [BCOL_W-1:0]         byte_column;
    logic [BYTE_W-1:0]         source_byte;
    logic signed [START_W-1:0] start_column;
    logic [DIM_W-1:0]          bitmap_width;
    logic [DIM_W-1:0]          canvas_width;
    logic                      row_ok;
  } lane_geom_t;

  // Clamp a dimension setting to MAX_DIM
  function automatic logic [DIM_W-1:0] sat_dim(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] r;
    if (int'(v) > MAX_DIM) r = DIM_W'(MAX_DIM);
    else r = v;
    return r;
  endfunction

endpackage

FILE: src/cmbb_lane_mask.sv
module cmbb_lane_mask (
  input  cmbb_pkg::lane_geom_t           geom,
  output logic [cmbb_pkg::MASK_W-1:0]    write_mask
);
  import cmbb_pkg::*;

  logic signed [START_W:0] start_ext;

  assign start_ext = {geom.start_column[START_W-1], geom.start_column};

  // Test each lane: row in range, bit set, inside bitmap columns, inside canvas columns
  always_comb begin
    logic [BCOL_W+2:0]        col;
    logic signed [START_W:0]  cx;
    for (int k = 0; k < LANES; k++) begin
      col = {geom.byte_column, 3'(k)};
      cx  = start_ext + $signed((START_W+1)'(k));
      write_mask[k] = geom.row_ok
                    && geom.source_byte[LANES-1-k]
                    && ({1'b0, col} < geom.bitmap_width)
                    && !cx[START_W]
                    && (cx < $signed({2'b00, geom.canvas_width}));
    end
  end

endmodule

FILE: src/clipped_mono_bitmap_blit_core.sv
// Channel | Ports                        | Item
// in      | in_tvalid/in_tready/in_tdata | source row, byte column, source byte
// out     | out_tvalid/out_tready/out_tdata | row offset, start column, mask, ink
// cfg     | cfg_valid/cfg_ready/cfg_index/cfg_data | register write, always ready
//
// One item per cycle sustained while out_tready holds; an accepted item passes through
// the input register, then the result register.
// The critical path is the 11x13 row offset multiply between the two registers.
// rst_n is synchronous; it clears both stage valids and loads register defaults.
// A stalled output holds its item; the input register still fills behind it, and
// in_tready drops only when both stages are full and the output is stalled.
module clipped_mono_bitmap_blit_core (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // [9:0] source_row, [16:10] byte_column, [24:17] source_byte
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [cmbb_pkg::IN_DATA_W-1:0]       in_tdata,
  // [21:0] row_offset, [33:22] start_column, [41:34] write_mask, [49:42] pixel_value
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [cmbb_pkg::OUT_DATA_W-1:0]      out_tdata,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [cmbb_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [cmbb_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import cmbb_pkg::*;

  // Configuration registers
  logic [DIM_W-1:0]    origin_x_r, origin_y_r, bitmap_width_r, bitmap_height_r;
  logic [DIM_W-1:0]    canvas_width_r, canvas_height_r;
  logic [STRIDE_W-1:0] canvas_stride_r;
  logic [PIX_W-1:0]    ink_value_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_x_r      <= '0;
      origin_y_r      <= '0;
      bitmap_width_r  <= '0;
      bitmap_height_r <= '0;
      canvas_width_r  <= DIM_W'(1);
      canvas_height_r <= DIM_W'(1);
      canvas_stride_r <= STRIDE_W'(1);
      ink_value_r     <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_ORIGIN_X:      origin_x_r      <= cfg_data[DIM_W-1:0];
        REG_ORIGIN_Y:      origin_y_r      <= cfg_data[DIM_W-1:0];
        REG_BITMAP_WIDTH:  bitmap_width_r  <= cfg_data[DIM_W-1:0];
        REG_BITMAP_HEIGHT: bitmap_height_r <= cfg_data[DIM_W-1:0];
        REG_CANVAS_WIDTH:  canvas_width_r  <= cfg_data[DIM_W-1:0];
        REG_CANVAS_HEIGHT: canvas_height_r <= cfg_data[DIM_W-1:0];
        REG_CANVAS_STRIDE: canvas_stride_r <= cfg_data;
        REG_INK_VALUE:     ink_value_r     <= cfg_data[PIX_W-1:0];
        default: ;
      endcase
    end
  end

  // Pipeline handshake
  logic s1_valid_r, s1_valid_nxt;
  logic s2_valid_r, s2_valid_nxt;
  logic s1_adv;

  assign s1_adv    = !s2_valid_r || out_tready;
  assign in_tready = !s1_valid_r || s1_adv;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_tready) s1_valid_nxt = in_tvalid;
    s2_valid_nxt = s2_valid_r;
    if (s1_adv) s2_valid_nxt = s1_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      s2_valid_r <= s2_valid_nxt;
    end
  end

  // Input register
  logic [ROW_W-1:0]  row_r;
  logic [BCOL_W-1:0] bcol_r;
  logic [BYTE_W-1:0] bits_r;

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      row_r  <= in_tdata[ROW_W-1:0];
      bcol_r <= in_tdata[ROW_W+BCOL_W-1:ROW_W];
      bits_r <= in_tdata[ROW_W+BCOL_W+BYTE_W-1:ROW_W+BCOL_W];
    end
  end

  // Row placement and clipping
  logic [DIM_W-1:0]              bw, bh, cw, ch;
  logic signed [START_W-1:0]     cy;
  logic signed [START_W-1:0]     start_col;
  logic                          row_ok;
  logic [DIM_W+STRIDE_W-1:0]     product;
  logic [OFFS_W-1:0]             offset;
  lane_geom_t                    geom;
  logic [MASK_W-1:0]             mask;

  assign bw = sat_dim(bitmap_width_r);
  assign bh = sat_dim(bitmap_height_r);
  assign cw = sat_dim(canvas_width_r);
  assign ch = sat_dim(canvas_height_r);

  assign cy = $signed({origin_y_r[DIM_W-1], origin_y_r}) + $signed({2'b00, row_r});
  assign start_col = $signed({origin_x_r[DIM_W-1], origin_x_r})
                   + $signed({2'b00, bcol_r, 3'b000});

  assign row_ok = ({1'b0, row_r} < bh) && !cy[START_W-1]
                && (cy < $signed({1'b0, ch}));

  assign product = cy[DIM_W-1:0] * canvas_stride_r;
  assign offset  = row_ok ? product[OFFS_W-1:0] : '0;

  assign geom.byte_column  = bcol_r;
  assign geom.source_byte  = bits_r;
  assign geom.start_column = start_col;
  assign geom.bitmap_width = bw;
  assign geom.canvas_width = cw;
  assign geom.row_ok       = row_ok;

  cmbb_lane_mask u_lane_mask (
    .geom       (geom),
    .write_mask (mask)
  );

  // Result register
  logic [OFFS_W-1:0]  offset_r;
  logic [START_W-1:0] start_r;
  logic [MASK_W-1:0]  mask_r;
  logic [PIX_W-1:0]   pix_r;

  always_ff @(posedge clk) begin
    if (s1_adv && s1_valid_r) begin
      offset_r <= offset;
      start_r  <= start_col;
      mask_r   <= mask;
      pix_r    <= ink_value_r;
    end
  end

  assign out_tvalid = s2_valid_r;
  assign out_tdata  = {(OUT_DATA_W-OUT_RAW_W)'(0), pix_r, mask_r, start_r, offset_r};

endmodule

FILE: src/cmbb_checker.sv
module cmbb_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_tvalid,
  input logic                               in_tready,
  input logic [cmbb_pkg::IN_DATA_W-1:0]     in_tdata,
  input logic                               out_tvalid,
  input logic                               out_tready,
  input logic [cmbb_pkg::OUT_DATA_W-1:0]    out_tdata,
  input logic                               cfg_valid,
  input logic                               cfg_ready,
  input logic [cmbb_pkg::CFG_IDX_W-1:0]     cfg_index,
  input logic [cmbb_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import cmbb_pkg::*;

  localparam int MASK_LO  = OFFS_W + START_W;
  localparam int START_HI = OFFS_W + START_W - 1;

  // Reset empties the result stage
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

  // A stalled item holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled output item changed");

  // A new result traces back to an input accept through the input register
  a_origin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(in_tvalid && in_tready, 2))
    else $error("output item without input item");

  // Lane zero is never written left of the canvas
  a_lane0_clip: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[MASK_LO] |-> !out_tdata[START_HI])
    else $error("lane zero written at negative column");

endmodule

bind clipped_mono_bitmap_blit_core cmbb_checker u_cmbb_checker (.*);
